@@ src/positional_circular_list_top_macros.svh @@
// Assertion macros shared by the positional circular list RTL.
`ifndef POSITIONAL_CIRCULAR_LIST_TOP_MACROS_SVH
`define POSITIONAL_CIRCULAR_LIST_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PCL_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("list check failed");

// Next-cycle implication, disabled during reset.
`define PCL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("list check failed");

`endif

@@ src/pcl_pkg.sv @@
// Shared types and codes of the positional circular list.
package pcl_pkg;

    localparam int WORD_W = 32;
    localparam int POS_W  = 16;
    localparam int ACT_W  = 2;
    localparam int STAT_W = 2;
    localparam int CNT_W  = 7;
    localparam int STEP_W = $clog2(POS_W + 1);

    typedef logic signed [WORD_W-1:0] word_t;

    localparam logic [ACT_W-1:0] ACT_PUSH  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_POP   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_READ  = 2'd2;
    localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd3;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

    localparam logic [1:0] CELL_HOLD = 2'd0;
    localparam logic [1:0] CELL_INS  = 2'd1;
    localparam logic [1:0] CELL_DEL  = 2'd2;

    typedef struct packed {
        logic [1:0] op;   // hold, insert at k, delete at k
        logic       tap;  // drive the word at k onto the read tree
    } cell_ctrl_t;

endpackage

@@ src/pcl_mod_unit.sv @@
// Restoring remainder unit: position modulo list length, one bit per cycle.
module pcl_mod_unit #(
    parameter int LEN_W = 7
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [pcl_pkg::POS_W-1:0] dividend,
    input  logic [LEN_W-1:0]          divisor,
    output logic                      done,
    output logic [LEN_W-1:0]          rem
);
    import pcl_pkg::*;

    logic [POS_W-1:0]  dvd_reg;
    logic [LEN_W-1:0]  rem_reg;
    logic [LEN_W-1:0]  dsr_reg;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [LEN_W:0]    trial;
    logic [LEN_W:0]    diff;
    logic [LEN_W-1:0]  rem_next;

    always_comb
    begin
        trial = {rem_reg, dvd_reg[POS_W-1]};
        diff  = trial - {1'b0, dsr_reg};
        if (trial >= {1'b0, dsr_reg})
        begin
            rem_next = diff[LEN_W-1:0];
        end
        else
        begin
            rem_next = trial[LEN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (step_reg == STEP_W'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(POS_W);
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - STEP_W'(1);
                if (step_reg == STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[POS_W-2:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

@@ src/pcl_cell.sv @@
// One list slot: holds a word, shifts with its neighbors on insert and delete.
module pcl_cell #(
    parameter int IDX_W = 6,
    parameter int INDEX = 0
) (
    input  logic                clk,
    input  pcl_pkg::cell_ctrl_t ctrl,
    input  logic [IDX_W-1:0]    k,
    input  pcl_pkg::word_t      left,
    input  pcl_pkg::word_t      right,
    input  pcl_pkg::word_t      ins,
    output pcl_pkg::word_t      word,
    output pcl_pkg::word_t      tap_word
);
    import pcl_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    word_t word_reg;
    logic  is_eq;
    logic  is_gt;

    assign is_eq = (MY_IDX == k);
    assign is_gt = (MY_IDX > k);

    always_ff @(posedge clk)
    begin
        unique case (ctrl.op)
            CELL_INS:
            begin
                if (is_eq)
                begin
                    word_reg <= ins;
                end
                else if (is_gt)
                begin
                    word_reg <= left;
                end
            end
            CELL_DEL:
            begin
                if (is_eq || is_gt)
                begin
                    word_reg <= right;
                end
            end
            default:
            begin
                word_reg <= word_reg;
            end
        endcase
    end

    assign word     = word_reg;
    assign tap_word = (ctrl.tap && is_eq) ? word_reg : '0;

endmodule

@@ src/pcl_or_tree.sv @@
// Registered binary OR tree that collects the one tapped cell word.
module pcl_or_tree #(
    parameter int N = 64
) (
    input  logic           clk,
    input  pcl_pkg::word_t leaf [N],
    output pcl_pkg::word_t root
);
    import pcl_pkg::*;

    localparam int DEPTH = $clog2(N);
    localparam int P     = 1 << DEPTH;

    word_t pad      [P];
    word_t node_reg [1:P-1];

    for (genvar j = 0; j < P; j++)
    begin : g_pad
        if (j < N)
        begin : g_live
            assign pad[j] = leaf[j];
        end
        else
        begin : g_zero
            assign pad[j] = '0;
        end
    end

    for (genvar i = 1; i < P; i++)
    begin : g_node
        if (2 * i >= P)
        begin : g_bottom
            always_ff @(posedge clk)
            begin
                node_reg[i] <= pad[2*i-P] | pad[2*i+1-P];
            end
        end
        else
        begin : g_inner
            always_ff @(posedge clk)
            begin
                node_reg[i] <= node_reg[2*i] | node_reg[2*i+1];
            end
        end
    end

    assign root = node_reg[1];

endmodule

@@ src/positional_circular_list_top.sv @@
// Top level of the positional circular list: control, cell chain, read tree, output register.
// Paths: clear, refused push and empty pop/read go straight to finish; push at position 0
//   or into an empty list goes to the edit step; other push runs the remainder unit, then edit;
//   pop at position 0 taps the read tree, then edit; read runs the remainder unit, then the tap;
//   other pop runs the remainder unit, the tap and the edit. Throughput: one item at a time;
//   the 16-step bit-serial remainder unit dominates. A new item is taken while the previous
//   result still waits in the output register.
// Reset (rst_n low, async): length cleared, output empty; cell words are not cleared.
module positional_circular_list_top #(
    parameter int CAPACITY = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // [31:0] value, [47:32] position
    input  logic [1:0]  s_tuser,   // [1:0] action
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] data, [38:32] count, [39] zero
    output logic [1:0]  m_tuser    // [1:0] status
);
    import pcl_pkg::*;
    `include "positional_circular_list_top_macros.svh"

    localparam int LEN_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int TD    = $clog2(CAPACITY);
    localparam int TW    = $clog2(TD + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_TAP  = 3'd2;
    localparam logic [2:0] S_EDIT = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    localparam logic [LEN_W-1:0] FULL_LEN = LEN_W'(CAPACITY);

    logic [2:0]        state_reg;
    logic [ACT_W-1:0]  act_reg;
    word_t             val_reg;
    logic [IDX_W-1:0]  k_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [TW-1:0]     tap_cnt_reg;
    word_t             res_data_reg;
    logic [STAT_W-1:0] res_stat_reg;

    logic              m_valid_reg;
    word_t             m_data_reg;
    logic [STAT_W-1:0] m_stat_reg;
    logic [CNT_W-1:0]  m_count_reg;

    // incoming fields
    logic              s_acc;
    logic [ACT_W-1:0]  in_act;
    word_t             in_val;
    logic [POS_W-1:0]  in_pos;

    // remainder unit
    logic              div_start;
    logic [POS_W-1:0]  div_dividend;
    logic              div_done;
    logic [LEN_W-1:0]  div_rem;
    logic [IDX_W-1:0]  rem_idx;
    logic [IDX_W-1:0]  len_idx;

    // cell chain
    cell_ctrl_t        ctrl;
    word_t             cell_word [CAPACITY];
    word_t             tap_word  [CAPACITY];
    word_t             tree_root;

    logic              out_free;
    logic [LEN_W+CNT_W-1:0] len_ext;

    assign s_acc    = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign in_act   = s_tuser;
    assign in_val   = s_tdata[31:0];
    assign in_pos   = s_tdata[47:32];
    assign rem_idx  = div_rem[IDX_W-1:0];
    assign len_idx  = len_reg[IDX_W-1:0];
    assign out_free = !m_valid_reg || m_tready;
    assign len_ext  = {{CNT_W{1'b0}}, len_reg};

    // Push/pop use (position - 1) mod length, read uses position mod length.
    // Position 0 on push/pop, every empty case and a push into a full list bypass the unit.
    always_comb
    begin
        div_dividend = in_pos - POS_W'(1);
        div_start    = 1'b0;
        if (s_acc && (len_reg != '0))
        begin
            priority if (in_act == ACT_READ)
            begin
                div_dividend = in_pos;
                div_start    = 1'b1;
            end
            else if ((in_act == ACT_POP) && (in_pos != '0))
            begin
                div_start = 1'b1;
            end
            else if ((in_act == ACT_PUSH) && (in_pos != '0) && (len_reg != FULL_LEN))
            begin
                div_start = 1'b1;
            end
            else
            begin
                div_start = 1'b0;
            end
        end
    end

    // Cells shift only in the edit cycle; the tap stays on while the tree fills.
    always_comb
    begin
        ctrl.op  = CELL_HOLD;
        ctrl.tap = (state_reg == S_TAP);
        if (state_reg == S_EDIT)
        begin
            ctrl.op = (act_reg == ACT_PUSH) ? CELL_INS : CELL_DEL;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            len_reg     <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            // result register: load on finish, drop once the transfer is taken
            if ((state_reg == S_FIN) && out_free)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_valid_reg && m_tready)
            begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_acc)
                    begin
                        unique case (in_act)
                            ACT_PUSH:
                            begin
                                priority if (len_reg == FULL_LEN)
                                begin
                                    state_reg <= S_FIN;
                                end
                                else if (len_reg == '0)
                                begin
                                    state_reg <= S_EDIT;
                                end
                                else if (in_pos == '0)
                                begin
                                    state_reg <= S_EDIT;
                                end
                                else
                                begin
                                    state_reg <= S_DIV;
                                end
                            end
                            ACT_POP:
                            begin
                                priority if (len_reg == '0)
                                begin
                                    state_reg <= S_FIN;
                                end
                                else if (in_pos == '0)
                                begin
                                    state_reg <= S_TAP;
                                end
                                else
                                begin
                                    state_reg <= S_DIV;
                                end
                            end
                            ACT_READ:
                            begin
                                state_reg <= (len_reg == '0) ? S_FIN : S_DIV;
                            end
                            default:
                            begin
                                len_reg   <= '0;
                                state_reg <= S_FIN;
                            end
                        endcase
                    end
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= (act_reg == ACT_PUSH) ? S_EDIT : S_TAP;
                    end
                end
                S_TAP:
                begin
                    if (tap_cnt_reg == '0)
                    begin
                        state_reg <= (act_reg == ACT_POP) ? S_EDIT : S_FIN;
                    end
                end
                S_EDIT:
                begin
                    if (act_reg == ACT_PUSH)
                    begin
                        len_reg <= len_reg + LEN_W'(1);
                    end
                    else
                    begin
                        len_reg <= len_reg - LEN_W'(1);
                    end
                    state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Item payload, slot index and result words.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_acc)
                begin
                    act_reg      <= in_act;
                    val_reg      <= in_val;
                    res_data_reg <= '0;
                    tap_cnt_reg  <= TW'(TD);
                    if ((in_act == ACT_PUSH) && (len_reg == FULL_LEN))
                    begin
                        res_stat_reg <= STAT_FULL;
                    end
                    else if ((in_act == ACT_POP || in_act == ACT_READ) && (len_reg == '0))
                    begin
                        res_stat_reg <= STAT_EMPTY;
                    end
                    else
                    begin
                        res_stat_reg <= STAT_OK;
                    end
                    // slot zero on push means append at the tail
                    if ((in_act == ACT_PUSH) && (in_pos == '0) && (len_reg != FULL_LEN))
                    begin
                        k_reg <= len_idx;
                    end
                    else
                    begin
                        k_reg <= '0;
                    end
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    if ((act_reg == ACT_PUSH) && (div_rem == '0))
                    begin
                        k_reg <= len_idx;
                    end
                    else
                    begin
                        k_reg <= rem_idx;
                    end
                end
            end
            S_TAP:
            begin
                if (tap_cnt_reg == '0)
                begin
                    res_data_reg <= tree_root;
                end
                else
                begin
                    tap_cnt_reg <= tap_cnt_reg - TW'(1);
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    m_data_reg  <= res_data_reg;
                    m_stat_reg  <= res_stat_reg;
                    m_count_reg <= len_ext[CNT_W-1:0];
                end
            end
            default:
            begin
                k_reg <= k_reg;
            end
        endcase
    end

    pcl_mod_unit #(
        .LEN_W (LEN_W)
    ) u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (len_reg),
        .done     (div_done),
        .rem      (div_rem)
    );

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        word_t left_w;
        word_t right_w;

        if (i == 0)
        begin : g_head
            assign left_w = '0;
        end
        else
        begin : g_mid_l
            assign left_w = cell_word[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_tail
            assign right_w = '0;
        end
        else
        begin : g_mid_r
            assign right_w = cell_word[i+1];
        end

        pcl_cell #(
            .IDX_W (IDX_W),
            .INDEX (i)
        ) u_cell (
            .clk      (clk),
            .ctrl     (ctrl),
            .k        (k_reg),
            .left     (left_w),
            .right    (right_w),
            .ins      (val_reg),
            .word     (cell_word[i]),
            .tap_word (tap_word[i])
        );
    end

    pcl_or_tree #(
        .N (CAPACITY)
    ) u_tree (
        .clk  (clk),
        .leaf (tap_word),
        .root (tree_root)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_count_reg, m_data_reg};
    assign m_tuser  = m_stat_reg;

    `PCL_ASSERT_NOW(a_len_bound, 1'b1, len_reg <= FULL_LEN)
    `PCL_ASSERT_NOW(a_div_only_in_div, div_done, state_reg == S_DIV)
    `PCL_ASSERT_NOW(a_tap_in_range, state_reg == S_TAP, k_reg < len_reg)
    `PCL_ASSERT_NEXT(a_full_push_keeps_len, s_acc && (in_act == ACT_PUSH) && (len_reg == FULL_LEN), len_reg == $past(len_reg))

endmodule
